FILE: rtl/core/u8dec_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8dec_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVERLONG    = 3'd1,
    ST_C1          = 3'd2,
    ST_SURROGATE   = 3'd3,
    ST_NOT_UNICODE = 3'd4,
    ST_SOLITARY    = 3'd5,
    ST_CONT_EXP    = 3'd6,
    ST_STRAY       = 3'd7
  } status_t;

  localparam logic [31:0] QMARK_CP     = 32'h0000_003F;
  localparam logic [31:0] LIM_1BYTE    = 32'h0000_007F;
  localparam logic [31:0] LIM_C1       = 32'h0000_009F;
  localparam logic [31:0] LIM_2BYTE    = 32'h0000_07FF;
  localparam logic [31:0] SURR_LO      = 32'h0000_D800;
  localparam logic [31:0] SURR_HI      = 32'h0000_DFFF;
  localparam logic [31:0] LIM_3BYTE    = 32'h0000_FFFF;
  localparam logic [31:0] LIM_UNICODE  = 32'h0010_FFFF;
  localparam logic [31:0] LIM_4BYTE    = 32'h001F_FFFF;
  localparam logic [31:0] LIM_5BYTE    = 32'h03FF_FFFF;

  typedef struct packed {
    logic [31:0] code_point;
    status_t     status;
    logic [2:0]  valid_length;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } job_t;

endpackage

FILE: rtl/core/u8dec_if.sv
// Handshake channels for byte input and decoded results.
interface u8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface u8dec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic [2:0]  status;
  logic [2:0]  valid_length;
  logic        last_result;

  modport source (output valid, output code_point, output status, output valid_length,
                  output last_result, input ready);
  modport sink (input valid, input code_point, input status, input valid_length,
                input last_result, output ready);
endinterface

FILE: rtl/core/u8dec_front.sv
// Front end: accepts bytes, tracks the pending sequence and builds result jobs.
module u8dec_front (
  input  logic             clk,
  input  logic             rst_n,
  u8dec_in_if.sink         in_ch,
  output logic             push,
  output u8dec_pkg::job_t  push_job,
  input  logic             push_ready
);
  import u8dec_pkg::*;

  logic [31:0] partial_r, partial_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [2:0]  missing_r, missing_nxt;
  logic [2:0]  seen_r, seen_nxt;

  logic        acc;
  logic [7:0]  b;
  logic        is_cont;
  logic        idle_has_res;
  result_t     idle_res;
  result_t     brk_res;
  result_t     done_res;
  logic [31:0] lead_pv;
  logic [2:0]  lead_missing;
  logic [31:0] pv_shift;
  logic [2:0]  seen_inc;
  status_t     done_st;

  function automatic status_t classify(input logic [31:0] v, input logic [2:0] total);
    status_t st;
    st = ST_OK;
    case (total)
      3'd2: begin
        if (v <= LIM_1BYTE) st = ST_OVERLONG;
        else if (v <= LIM_C1) st = ST_C1;
      end
      3'd3: begin
        if (v <= LIM_2BYTE) st = ST_OVERLONG;
        else if (v >= SURR_LO && v <= SURR_HI) st = ST_SURROGATE;
      end
      3'd4: begin
        if (v <= LIM_3BYTE) st = ST_OVERLONG;
        else if (v > LIM_UNICODE) st = ST_NOT_UNICODE;
      end
      3'd5: st = (v <= LIM_4BYTE) ? ST_OVERLONG : ST_NOT_UNICODE;
      default: st = (v <= LIM_5BYTE) ? ST_OVERLONG : ST_NOT_UNICODE;
    endcase
    return st;
  endfunction

  assign in_ch.ready = push_ready;
  assign acc         = in_ch.valid && push_ready;
  assign b           = in_ch.byte_in;
  assign is_cont     = (b[7:6] == 2'b10);
  assign idle_has_res = !b[7] || is_cont;
  assign pv_shift    = {partial_r[25:0], b[5:0]};
  assign seen_inc    = seen_r + 3'd1;
  assign done_st     = classify(pv_shift, seen_inc);

  always_comb begin
    idle_res.code_point   = {24'd0, b};
    idle_res.status       = b[7] ? ST_STRAY : ST_OK;
    idle_res.valid_length = b[7] ? 3'd0 : 3'd1;
    idle_res.last_result  = 1'b1;

    if (seen_r <= 3'd1) begin
      brk_res.code_point = {24'd0, lead_r};
      brk_res.status     = ST_SOLITARY;
    end else begin
      brk_res.code_point = QMARK_CP;
      brk_res.status     = ST_CONT_EXP;
    end
    brk_res.valid_length = 3'd0;
    brk_res.last_result  = 1'b1;

    done_res.code_point   = pv_shift;
    done_res.status       = done_st;
    done_res.valid_length = (done_st == ST_OK) ? seen_inc : 3'd0;
    done_res.last_result  = 1'b1;

    case (b) inside
      [8'hC0:8'hDF]: begin lead_pv = {27'd0, b[4:0]}; lead_missing = 3'd1; end
      [8'hE0:8'hEF]: begin lead_pv = {28'd0, b[3:0]}; lead_missing = 3'd2; end
      [8'hF0:8'hF7]: begin lead_pv = {29'd0, b[2:0]}; lead_missing = 3'd3; end
      [8'hF8:8'hFB]: begin lead_pv = {30'd0, b[1:0]}; lead_missing = 3'd4; end
      default:       begin lead_pv = {30'd0, b[1:0]}; lead_missing = 3'd5; end
    endcase
  end

  always_comb begin
    partial_nxt = partial_r;
    lead_nxt    = lead_r;
    missing_nxt = missing_r;
    seen_nxt    = seen_r;
    push        = 1'b0;
    push_job    = '0;
    if (acc) begin
      if (in_ch.end_of_input) begin
        if (missing_r != 3'd0) begin
          push           = 1'b1;
          push_job.first = brk_res;
          partial_nxt    = '0;
          lead_nxt       = '0;
          missing_nxt    = '0;
          seen_nxt       = '0;
        end
      end else if (missing_r == 3'd0) begin
        if (idle_has_res) begin
          push           = 1'b1;
          push_job.first = idle_res;
        end else begin
          partial_nxt = lead_pv;
          lead_nxt    = b;
          missing_nxt = lead_missing;
          seen_nxt    = 3'd1;
        end
      end else if (is_cont) begin
        partial_nxt = pv_shift;
        seen_nxt    = seen_inc;
        missing_nxt = missing_r - 3'd1;
        if (missing_r == 3'd1) begin
          push           = 1'b1;
          push_job.first = done_res;
          partial_nxt    = '0;
          lead_nxt       = '0;
          missing_nxt    = '0;
          seen_nxt       = '0;
        end
      end else begin
        // report the break, then decode the byte again from idle
        push           = 1'b1;
        push_job.first = brk_res;
        if (idle_has_res) begin
          push_job.two                     = 1'b1;
          push_job.first.last_result       = 1'b0;
          push_job.second                  = idle_res;
          partial_nxt                      = '0;
          lead_nxt                         = '0;
          missing_nxt                      = '0;
          seen_nxt                         = '0;
        end else begin
          partial_nxt = lead_pv;
          lead_nxt    = b;
          missing_nxt = lead_missing;
          seen_nxt    = 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      lead_r    <= '0;
      missing_r <= '0;
      seen_r    <= '0;
    end else begin
      partial_r <= partial_nxt;
      lead_r    <= lead_nxt;
      missing_r <= missing_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

FILE: rtl/core/u8dec_queue.sv
// Job queue between the front end and the result sequencer.
module u8dec_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8dec_pkg::job_t  push_job,
  output logic             push_ready,
  input  logic             pop,
  output u8dec_pkg::job_t  pop_job,
  output logic             pop_valid
);
  import u8dec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = store_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/u8dec_back.sv
// Back end: holds one job and hands out its results one item at a time.
module u8dec_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  u8dec_pkg::job_t  pop_job,
  output logic             pop,
  u8dec_out_if.source      out_ch
);
  import u8dec_pkg::*;

  logic    valid_r, valid_nxt;
  logic    second_r, second_nxt;
  job_t    job_r;
  result_t cur;
  logic    take;
  logic    job_done;

  assign cur      = second_r ? job_r.second : job_r.first;
  assign take     = valid_r && out_ch.ready;
  assign job_done = take && (second_r || !job_r.two);
  assign pop      = pop_valid && (!valid_r || job_done);

  assign out_ch.valid        = valid_r;
  assign out_ch.code_point   = cur.code_point;
  assign out_ch.status       = cur.status;
  assign out_ch.valid_length = cur.valid_length;
  assign out_ch.last_result  = cur.last_result;

  always_comb begin
    valid_nxt  = valid_r;
    second_nxt = second_r;
    if (take && job_r.two && !second_r) begin
      second_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt  = 1'b1;
      second_nxt = 1'b0;
    end else if (job_done) begin
      valid_nxt  = 1'b0;
      second_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= pop_job;
    end
  end

endmodule

FILE: rtl/core/utf8_stream_decoder_checked_core.sv
// Top level of the checked UTF-8 stream decoder.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid / ready      byte_in[7:0], end_of_input
//   out_ch    out  valid / ready      code_point[31:0], status[2:0], valid_length[2:0],
//                                     last_result
//
// One byte is taken per cycle while the job queue has room; the decode step is combinational
// in the front end. A byte that breaks a sequence and is itself a result gives two items,
// which leave the output register one after the other; the job queue absorbs the difference.
// An accepted byte's job is registered in the job queue, then in the back end's job register.
// rst_n is synchronous; after reset the decoder is idle with the queue empty.
// in_ch.ready falls only when the job queue is full.
module utf8_stream_decoder_checked_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  u8dec_in_if.sink    in_ch,
  u8dec_out_if.source out_ch
);
  import u8dec_pkg::*;

  logic push;
  job_t push_job;
  logic push_ready;
  logic pop;
  job_t pop_job;
  logic pop_valid;

  u8dec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  u8dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid)
  );

  u8dec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty job queue");

  a_second_item_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_result) |=> out_ch.valid)
    else $error("second item of a job missing");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> push_ready)
    else $error("item accepted with job queue full");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Checks the UTF-8 stream decoder against a scoreboard fed by directed and random byte streams.
module testbench;
  import u8dec_pkg::*;

  logic clk;
  logic rst_n;

  u8dec_in_if  in_ch ();
  u8dec_out_if out_ch ();

  utf8_stream_decoder_checked_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [31:0] dec_value;
  logic [7:0]  dec_lead;
  logic [2:0]  dec_missing;
  logic [2:0]  dec_seen;

  result_t expected_results[$];
  result_t step_results[$];

  int   mismatches     = 0;
  int   bytes_sent     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  logic long_hold_req  = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t make_result(logic [31:0] cp, status_t st, logic [2:0] len);
    result_t r;
    r.code_point   = cp;
    r.status       = st;
    r.valid_length = len;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic void clear_decoder();
    dec_value   = '0;
    dec_lead    = '0;
    dec_missing = '0;
    dec_seen    = '0;
  endfunction

  function automatic void flush_pending();
    if (dec_seen <= 3'd1) begin
      step_results.push_back(make_result({24'd0, dec_lead}, ST_SOLITARY, 3'd0));
    end else begin
      step_results.push_back(make_result(QMARK_CP, ST_CONT_EXP, 3'd0));
    end
    clear_decoder();
  endfunction

  function automatic void decode_from_idle(logic [7:0] b);
    if (b < 8'h80) begin
      step_results.push_back(make_result({24'd0, b}, ST_OK, 3'd1));
    end else if (b <= 8'hBF) begin
      step_results.push_back(make_result({24'd0, b}, ST_STRAY, 3'd0));
    end else begin
      dec_lead = b;
      dec_seen = 3'd1;
      if (b <= 8'hDF) begin
        dec_value   = {27'd0, b[4:0]};
        dec_missing = 3'd1;
      end else if (b <= 8'hEF) begin
        dec_value   = {28'd0, b[3:0]};
        dec_missing = 3'd2;
      end else if (b <= 8'hF7) begin
        dec_value   = {29'd0, b[2:0]};
        dec_missing = 3'd3;
      end else if (b <= 8'hFB) begin
        dec_value   = {30'd0, b[1:0]};
        dec_missing = 3'd4;
      end else begin
        dec_value   = {30'd0, b[1:0]};
        dec_missing = 3'd5;
      end
    end
  endfunction

  function automatic void predict_item(logic [7:0] b, logic eoi);
    status_t st;
    step_results.delete();
    if (eoi) begin
      if (dec_missing != 3'd0) flush_pending();
    end else if (dec_missing == 3'd0) begin
      decode_from_idle(b);
    end else if (b >= 8'h80 && b <= 8'hBF) begin
      dec_value   = {dec_value[25:0], b[5:0]};
      dec_seen    = dec_seen + 3'd1;
      dec_missing = dec_missing - 3'd1;
      if (dec_missing == 3'd0) begin
        st = ST_OK;
        case (dec_seen)
          3'd2: begin
            if (dec_value <= LIM_1BYTE) st = ST_OVERLONG;
            else if (dec_value <= LIM_C1) st = ST_C1;
          end
          3'd3: begin
            if (dec_value <= LIM_2BYTE) st = ST_OVERLONG;
            else if (dec_value >= SURR_LO && dec_value <= SURR_HI) st = ST_SURROGATE;
          end
          3'd4: begin
            if (dec_value <= LIM_3BYTE) st = ST_OVERLONG;
            else if (dec_value > LIM_UNICODE) st = ST_NOT_UNICODE;
          end
          3'd5: begin
            st = (dec_value <= LIM_4BYTE) ? ST_OVERLONG : ST_NOT_UNICODE;
          end
          default: begin
            st = (dec_value <= LIM_5BYTE) ? ST_OVERLONG : ST_NOT_UNICODE;
          end
        endcase
        step_results.push_back(make_result(dec_value, st, (st == ST_OK) ? dec_seen : 3'd0));
        clear_decoder();
      end
    end else begin
      flush_pending();
      decode_from_idle(b);
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last_result = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.byte_in      <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(b, eoi);
    if (!eoi) bytes_sent++;
  endtask

  task automatic send_random_sequence();
    int         kind;
    int         pick;
    int         total;
    int         keep;
    int         r;
    logic [7:0] lead;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_item(8'($urandom_range(8'h7F)), 1'b0);
    end else if (kind < 85) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        total = 2;
        lead  = 8'hC0 | 8'($urandom_range(8'h1F));
      end else if (pick < 60) begin
        total = 3;
        lead  = 8'hE0 | 8'($urandom_range(8'h0F));
      end else if (pick < 85) begin
        total = 4;
        lead  = 8'hF0 | 8'($urandom_range(8'h07));
      end else if (pick < 93) begin
        total = 5;
        lead  = 8'hF8 | 8'($urandom_range(8'h03));
      end else begin
        total = 6;
        lead  = 8'hFC | 8'($urandom_range(8'h03));
      end
      keep = (kind < 70) ? total - 1 : $urandom_range(total - 2);
      send_item(lead, 1'b0);
      for (int k = 0; k < keep; k++) send_item(8'h80 | 8'($urandom_range(8'h3F)), 1'b0);
      if (kind >= 70) begin
        // break the sequence with end of input or a non-continuation byte
        if ($urandom_range(3) == 0) begin
          send_item(8'($urandom_range(255)), 1'b1);
        end else begin
          r = $urandom_range(191);
          send_item(8'((r < 128) ? r : r + 64), 1'b0);
        end
      end
    end else if (kind < 95) begin
      send_item(8'($urandom_range(255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_sequence();
  endtask

  task automatic test_directed();
    logic [8:0] seq[$] = '{
      9'h000, 9'h07F, 9'h0BF,
      9'h0C2, 9'h09F,
      9'h0DF, 9'h0BF,
      9'h0ED, 9'h0A0, 9'h080,
      9'h0F4, 9'h090, 9'h080, 9'h080,
      9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0C0, 9'h041,
      9'h0E2, 9'h082, 9'h0C3, 9'h100,
      9'h1FF
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (seq[i]) send_item(seq[i][7:0], seq[i][8]);
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(90);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 65;
    recv_stall_pct = 0;
    run_random(90);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 65;
    run_random(90);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    run_random(90);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req <= 1'b1;
    // each lead broken by an ASCII byte gives two items, and the held-off receiver lets the queue fill
    for (int i = 0; i < 20; i++) begin
      send_item(8'hC3, 1'b0);
      send_item(8'(8'h41 + i), 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left     <= 400;
      out_ch.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: expected nothing, actual cp=%h status=%0d len=%0d last=%b", $time,
                 out_ch.code_point, out_ch.status, out_ch.valid_length, out_ch.last_result);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.code_point !== exp_r.code_point || out_ch.status !== exp_r.status ||
            out_ch.valid_length !== exp_r.valid_length ||
            out_ch.last_result !== exp_r.last_result) begin
          $display("%0t: expected cp=%h status=%0d len=%0d last=%b", $time,
                   exp_r.code_point, exp_r.status, exp_r.valid_length, exp_r.last_result,
                   ", actual cp=%h status=%0d len=%0d last=%b",
                   out_ch.code_point, out_ch.status, out_ch.valid_length, out_ch.last_result);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.byte_in      = 8'd0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    clear_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_backpressure();
    test_receiver_stall();
    test_both_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_if.sv
rtl/core/u8dec_front.sv
rtl/core/u8dec_queue.sv
rtl/core/u8dec_back.sv
rtl/core/utf8_stream_decoder_checked_core.sv
test/testbench.sv
